[rtl/hfbr_pkg.sv]
// Shared types and codes for the header-framed block receiver.
// No dependencies; used by header_framed_block_receiver_unit.
`default_nettype none
package hfbr_pkg;

    localparam logic [1:0] ACT_RECV = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] CFG_HEADER_LEN   = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

    localparam logic [6:0]  BLOCK_SIZE_RST   = 7'd8;
    localparam logic [2:0]  HEADER_LEN_RST   = 3'd2;
    localparam logic [31:0] HEADER_BYTES_RST = 32'h0000_55AA;

    localparam int CFG_DATA_W = 32;

    // Status fields carried on every result item.
    typedef struct packed {
        logic       overflow_seen;
        logic [2:0] blocks_ready;
        logic       receiving;
    } t_status;

endpackage
`default_nettype wire

[rtl/hfbr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module hfbr_ram #(
    parameter int W = 8,
    parameter int D = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/header_framed_block_receiver_unit.sv]
// Header-framed block receiver: cuts received bytes into fixed-length blocks kept in a ring.
// Receive items need a free output; each result is registered in the cycle after acceptance.
// Read and peek look up the slot length, then stream one byte per cycle from the store's
// single read port while the output is not stalled; new items wait until the last byte is out.
// Reset (synchronous, active low) empties the ring and restores register defaults;
// the block store and length table are not cleared. Depends on hfbr_pkg and hfbr_ram.
`default_nettype none
module header_framed_block_receiver_unit #(
    parameter int SLOTS     = 8,
    parameter int BLOCK_MAX = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [1:0]                   i_action,
    input  wire logic [7:0]                   i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [7:0]                   o_data_byte,
    output logic                              o_last,
    output logic                              o_block_valid,
    output logic                              o_byte_accepted,
    output logic                              o_overflow_seen,
    output logic      [2:0]                   o_blocks_ready,
    output logic                              o_receiving,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_idx,
    input  wire logic [hfbr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int FW = $clog2(BLOCK_MAX + 1);
    localparam int OW = $clog2(BLOCK_MAX);
    localparam int AW = $clog2(SLOTS * BLOCK_MAX);
    localparam int CW = (SW + 1 > 3) ? SW + 1 : 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_STREAM
    } t_state;

    t_state r_state, n_state;

    logic [6:0]  r_block_size;
    logic [2:0]  r_header_len;
    logic [31:0] r_header_bytes;

    logic [SW-1:0] r_head, n_head, r_tail, n_tail, r_rd_slot, n_rd_slot;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_asm, n_asm, r_ovf, n_ovf;
    logic [FW-1:0] r_len, n_len, r_rd_idx, n_rd_idx, r_out_idx, n_out_idx;
    logic          r_dv, n_dv;

    logic          r_o_valid, n_o_valid;
    logic [7:0]    r_o_data, n_o_data;
    logic          r_o_last, n_o_last, r_o_bvalid, n_o_bvalid, r_o_acc, n_o_acc;
    hfbr_pkg::t_status r_o_status, n_o_status;

    logic          out_free, in_accept;
    logic [FW-1:0] bs_eff, hl_eff, fill_base, fill_inc, len_clamped;
    logic [SW-1:0] head_inc, tail_inc;
    logic          ring_full, ring_empty;
    logic [CW-1:0] cnt;
    logic [7:0]    hdr_sel, hdr0;

    logic          st_we, st_re, len_we, len_re, store, load_out;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_rdata;
    logic [FW-1:0] len_rdata;

    assign out_free  = !r_o_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || !out_free;
    assign in_accept = i_valid && !o_stall;

    assign head_inc   = (r_head == SW'(SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc   = (r_tail == SW'(SLOTS - 1)) ? '0 : r_tail + 1'b1;
    assign ring_full  = (head_inc == r_tail);
    assign ring_empty = (r_head == r_tail);

    always_comb begin
        if (r_block_size == 7'd0) begin
            bs_eff = FW'(1);
        end else if (r_block_size > 7'(BLOCK_MAX)) begin
            bs_eff = FW'(BLOCK_MAX);
        end else begin
            bs_eff = FW'(r_block_size);
        end
        hl_eff = (r_header_len > 3'd4) ? FW'(4) : FW'(r_header_len);
        if (len_rdata == '0) begin
            len_clamped = FW'(1);
        end else if (len_rdata > FW'(BLOCK_MAX)) begin
            len_clamped = FW'(BLOCK_MAX);
        end else begin
            len_clamped = len_rdata;
        end
    end

    assign hdr0    = r_header_bytes[7:0];
    assign hdr_sel = r_header_bytes[8 * r_fill[1:0] +: 8];

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_asm      = r_asm;
        n_ovf      = r_ovf;
        n_rd_slot  = r_rd_slot;
        n_len      = r_len;
        n_rd_idx   = r_rd_idx;
        n_out_idx  = r_out_idx;
        n_dv       = r_dv;
        n_o_valid  = r_o_valid && i_stall;
        n_o_data   = r_o_data;
        n_o_last   = r_o_last;
        n_o_bvalid = r_o_bvalid;
        n_o_acc    = r_o_acc;
        st_we      = 1'b0;
        st_re      = 1'b0;
        len_we     = 1'b0;
        len_re     = 1'b0;
        store      = 1'b0;
        fill_base  = r_fill;
        fill_inc   = r_fill;
        load_out   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = 8'd0;
                    n_o_last   = 1'b1;
                    n_o_bvalid = 1'b0;
                    n_o_acc    = 1'b0;
                    if (i_action == hfbr_pkg::ACT_RECV) begin
                        if (ring_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_o_acc = 1'b1;
                            if (!r_asm) begin
                                if (hl_eff == '0 || i_rx_byte == hdr0) begin
                                    store     = 1'b1;
                                    fill_base = '0;
                                end
                            end else if (r_fill < hl_eff && i_rx_byte != hdr_sel) begin
                                // header mismatch: drop the partial block
                                n_asm  = 1'b0;
                                n_fill = '0;
                            end else begin
                                store = 1'b1;
                            end
                            if (store) begin
                                if (fill_base < FW'(BLOCK_MAX)) begin
                                    st_we    = 1'b1;
                                    fill_inc = fill_base + 1'b1;
                                end else begin
                                    fill_inc = fill_base;
                                end
                                if (fill_inc >= bs_eff) begin
                                    len_we = 1'b1;
                                    n_head = head_inc;
                                    n_fill = '0;
                                    n_asm  = 1'b0;
                                end else begin
                                    n_fill = fill_inc;
                                    n_asm  = 1'b1;
                                end
                            end
                        end
                    end else if ((i_action == hfbr_pkg::ACT_READ ||
                                  i_action == hfbr_pkg::ACT_PEEK) && !ring_empty) begin
                        // no status item; look up the block length first
                        n_o_valid = r_o_valid && i_stall;
                        len_re    = 1'b1;
                        n_rd_slot = r_tail;
                        n_state   = S_LEN;
                        if (i_action == hfbr_pkg::ACT_READ) begin
                            n_tail = tail_inc;
                        end
                    end
                end
            end
            S_LEN: begin
                n_len     = len_clamped;
                n_rd_idx  = '0;
                n_out_idx = '0;
                n_dv      = 1'b0;
                n_state   = S_STREAM;
            end
            S_STREAM: begin
                load_out = r_dv && out_free;
                if (r_rd_idx < r_len && (!r_dv || load_out)) begin
                    st_re    = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_dv     = 1'b1;
                end else if (load_out) begin
                    n_dv = 1'b0;
                end
                if (load_out) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = st_rdata;
                    n_o_bvalid = 1'b1;
                    n_o_acc    = 1'b0;
                    n_o_last   = (r_out_idx + 1'b1 == r_len);
                    n_out_idx  = r_out_idx + 1'b1;
                    if (r_out_idx + 1'b1 == r_len) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // status after this step
        if (n_head >= n_tail) begin
            cnt = CW'(n_head) - CW'(n_tail);
        end else begin
            cnt = CW'(n_head) + CW'(SLOTS) - CW'(n_tail);
        end
        n_o_status.overflow_seen = n_ovf;
        n_o_status.blocks_ready  = (cnt > CW'(7)) ? 3'd7 : 3'(cnt);
        n_o_status.receiving     = n_asm || (n_fill != '0);
        if (!(n_o_valid && !(r_o_valid && i_stall))) begin
            n_o_status = r_o_status;
        end
    end

    assign st_waddr = AW'(r_head) * AW'(BLOCK_MAX) + AW'(fill_base[OW-1:0]);
    assign st_raddr = AW'(r_rd_slot) * AW'(BLOCK_MAX) + AW'(r_rd_idx[OW-1:0]);

    hfbr_ram #(.W(8), .D(SLOTS * BLOCK_MAX)) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(i_rx_byte),
        .i_re   (st_re),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    hfbr_ram #(.W(FW), .D(SLOTS)) u_len (
        .i_clk  (i_clk),
        .i_we   (len_we),
        .i_waddr(r_head),
        .i_wdata(fill_inc),
        .i_re   (len_re),
        .i_raddr(r_tail),
        .o_rdata(len_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= '0;
            r_tail         <= '0;
            r_fill         <= '0;
            r_asm          <= 1'b0;
            r_ovf          <= 1'b0;
            r_dv           <= 1'b0;
            r_o_valid      <= 1'b0;
            r_block_size   <= hfbr_pkg::BLOCK_SIZE_RST;
            r_header_len   <= hfbr_pkg::HEADER_LEN_RST;
            r_header_bytes <= hfbr_pkg::HEADER_BYTES_RST;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_asm     <= n_asm;
            r_ovf     <= n_ovf;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hfbr_pkg::CFG_BLOCK_SIZE:   r_block_size   <= i_cfg_data[6:0];
                    hfbr_pkg::CFG_HEADER_LEN:   r_header_len   <= i_cfg_data[2:0];
                    hfbr_pkg::CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
        end
        r_rd_slot  <= n_rd_slot;
        r_len      <= n_len;
        r_rd_idx   <= n_rd_idx;
        r_out_idx  <= n_out_idx;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
        r_o_bvalid <= n_o_bvalid;
        r_o_acc    <= n_o_acc;
        r_o_status <= n_o_status;
    end

    assign o_valid         = r_o_valid;
    assign o_data_byte     = r_o_data;
    assign o_last          = r_o_last;
    assign o_block_valid   = r_o_bvalid;
    assign o_byte_accepted = r_o_acc;
    assign o_overflow_seen = r_o_status.overflow_seen;
    assign o_blocks_ready  = r_o_status.blocks_ready;
    assign o_receiving     = r_o_status.receiving;

    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_asm |-> (r_fill == '0))
        else $error("fill count nonzero while not assembling");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(BLOCK_MAX))
        else $error("fill count beyond block maximum");

    a_stream_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> (r_out_idx < r_len && r_rd_idx <= r_len))
        else $error("stream index beyond block length");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM && n_o_valid && n_o_last && n_o_bvalid && !r_o_valid)
        |=> (r_state == S_IDLE))
        else $error("stream did not end after last byte");

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for header_framed_block_receiver_unit: a directed table of items and
// register writes, then random framed byte streams under several idling mixes. Depends on
// hfbr_pkg and the receiver RTL; output items are checked against predicted or pinned results.
module testbench;

    localparam int SLOTS     = 8;
    localparam int BLOCK_MAX = 64;
    localparam int LIMIT     = 400000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              last;
        logic              block_valid;
        logic              byte_accepted;
        hfbr_pkg::t_status status;
    } t_rx_out;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  sel;     // action or register index
        logic [31:0] value;   // received byte or register data
        bit          pinned;  // result typed in below, not predicted
        t_rx_out     result;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [1:0]                      i_action;
    logic [7:0]                      i_rx_byte;
    logic                            o_valid;
    logic                            i_stall;
    logic [7:0]                      o_data_byte;
    logic                            o_last;
    logic                            o_block_valid;
    logic                            o_byte_accepted;
    logic                            o_overflow_seen;
    logic [2:0]                      o_blocks_ready;
    logic                            o_receiving;
    logic                            i_cfg_we;
    logic [1:0]                      i_cfg_idx;
    logic [hfbr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state and register copies
    logic [7:0]  blk_mem [SLOTS*BLOCK_MAX];
    int unsigned blk_len [SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned fill_cnt;
    bit          in_block;
    bit          ovf_flag;
    logic [6:0]  cfg_bsize;
    logic [2:0]  cfg_hlen;
    logic [31:0] cfg_hdr;

    t_rx_out due_outputs[$];
    t_rx_out step_results[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      pin_on;
    t_rx_out pin_res;

    header_framed_block_receiver_unit #(
        .SLOTS(SLOTS),
        .BLOCK_MAX(BLOCK_MAX)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_action(i_action),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data_byte(o_data_byte),
        .o_last(o_last),
        .o_block_valid(o_block_valid),
        .o_byte_accepted(o_byte_accepted),
        .o_overflow_seen(o_overflow_seen),
        .o_blocks_ready(o_blocks_ready),
        .o_receiving(o_receiving),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    function automatic int unsigned eff_bsize();
        if (cfg_bsize == 7'd0) return 1;
        if (cfg_bsize > BLOCK_MAX) return BLOCK_MAX;
        return cfg_bsize;
    endfunction

    function automatic int unsigned eff_hlen();
        return (cfg_hlen > 3'd4) ? 4 : cfg_hlen;
    endfunction

    function automatic logic [7:0] hdr_byte(int unsigned i);
        return cfg_hdr[8*(i%4) +: 8];
    endfunction

    function automatic hfbr_pkg::t_status status_now();
        hfbr_pkg::t_status s;
        int unsigned       n;
        n = (wr_slot + SLOTS - rd_slot) % SLOTS;
        s.overflow_seen = ovf_flag;
        s.blocks_ready  = (n > 7) ? 3'd7 : 3'(n);
        s.receiving     = in_block || (fill_cnt > 0);
        return s;
    endfunction

    // Returns 0 when the byte is rejected for a full ring.
    function automatic bit take_byte(logic [7:0] c);
        int unsigned hl;
        int unsigned bs;
        hl = eff_hlen();
        bs = eff_bsize();
        if ((wr_slot + 1) % SLOTS == rd_slot) begin
            ovf_flag = 1'b1;
            return 1'b0;
        end
        if (!in_block) begin
            if (hl == 0 || c == hdr_byte(0)) begin
                in_block = 1'b1;
                fill_cnt = 0;
            end else begin
                return 1'b1;
            end
        end else if (fill_cnt < hl && c != hdr_byte(fill_cnt)) begin
            // drop the partial block; this byte does not restart one
            in_block = 1'b0;
            fill_cnt = 0;
            return 1'b1;
        end
        if (fill_cnt < BLOCK_MAX) begin
            blk_mem[wr_slot*BLOCK_MAX + fill_cnt] = c;
            fill_cnt++;
        end
        if (fill_cnt >= bs) begin
            blk_len[wr_slot] = fill_cnt;
            wr_slot  = (wr_slot + 1) % SLOTS;
            fill_cnt = 0;
            in_block = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void deframe_step(logic [1:0] act, logic [7:0] c);
        int unsigned len;
        int unsigned base;
        int unsigned k;
        bit          acc;
        t_rx_out     r;
        step_results.delete();
        if (act == hfbr_pkg::ACT_RECV) begin
            acc = take_byte(c);
            r = '0;
            r.last          = 1'b1;
            r.byte_accepted = acc;
            r.status        = status_now();
            step_results.push_back(r);
        end else if ((act == hfbr_pkg::ACT_READ || act == hfbr_pkg::ACT_PEEK) &&
                     rd_slot != wr_slot) begin
            len  = blk_len[rd_slot];
            if (len == 0) len = 1;
            if (len > BLOCK_MAX) len = BLOCK_MAX;
            base = rd_slot * BLOCK_MAX;
            if (act == hfbr_pkg::ACT_READ) begin
                blk_len[rd_slot] = 0;
                rd_slot = (rd_slot + 1) % SLOTS;
            end
            for (k = 0; k < len; k++) begin
                r = '0;
                r.data_byte   = blk_mem[base + k];
                r.last        = (k + 1 == len);
                r.block_valid = 1'b1;
                r.status      = status_now();
                step_results.push_back(r);
            end
        end else begin
            // empty ring or unused action: status only
            r = '0;
            r.last   = 1'b1;
            r.status = status_now();
            step_results.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic t_stim_row row_item(logic [1:0] act, logic [7:0] b);
        t_stim_row row;
        row.kind   = ROW_ITEM;
        row.sel    = act;
        row.value  = {24'd0, b};
        row.pinned = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic t_stim_row row_cfg(logic [1:0] idx, logic [31:0] v);
        t_stim_row row;
        row        = row_item(hfbr_pkg::ACT_RECV, 8'd0);
        row.kind   = ROW_CFG;
        row.sel    = idx;
        row.value  = v;
        return row;
    endfunction

    function automatic t_stim_row row_pin(logic [1:0] act, logic [7:0] b, logic [7:0] d,
                                          logic l, logic bv, logic acc, logic ov,
                                          logic [2:0] rdy, logic rcv);
        t_stim_row row;
        row = row_item(act, b);
        row.pinned = 1'b1;
        row.result = '{data_byte: d, last: l, block_valid: bv, byte_accepted: acc,
                       status: '{overflow_seen: ov, blocks_ready: rdy, receiving: rcv}};
        return row;
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid   = 1'b0;
            i_action  = 2'($urandom);
            i_rx_byte = 8'($urandom);
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_action  = act;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            hfbr_pkg::CFG_BLOCK_SIZE:   cfg_bsize = val[6:0];
            hfbr_pkg::CFG_HEADER_LEN:   cfg_hlen  = val[2:0];
            hfbr_pkg::CFG_HEADER_BYTES: cfg_hdr   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Drop valid and hold until every expected item has come out.
    task automatic settle_idle();
        i_valid = 1'b0;
        while (due_outputs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("header_framed_block_receiver_unit: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_rx_out want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                deframe_step(i_action, i_rx_byte);
                if (pin_on) due_outputs.push_back(pin_res);
                else foreach (step_results[k]) due_outputs.push_back(step_results[k]);
            end
            if (o_valid && !i_stall) begin
                if (due_outputs.size() == 0) begin
                    errors++;
                    $display("%0t: item with none expected: data %0h last %0b valid %0b",
                             $time, o_data_byte, o_last, o_block_valid);
                end else begin
                    want = due_outputs.pop_front();
                    check_field("data_byte", want.data_byte, o_data_byte);
                    check_field("last", want.last, o_last);
                    check_field("block_valid", want.block_valid, o_block_valid);
                    check_field("byte_accepted", want.byte_accepted, o_byte_accepted);
                    check_field("overflow_seen", want.status.overflow_seen, o_overflow_seen);
                    check_field("blocks_ready", want.status.blocks_ready, o_blocks_ready);
                    check_field("receiving", want.status.receiving, o_receiving);
                end
            end
        end
    end

    initial begin
        t_stim_row   rows[$];
        int unsigned sent;
        int unsigned hl;
        int unsigned bs;
        int unsigned k;
        int unsigned cut;
        int unsigned pick;
        int          p;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = hfbr_pkg::ACT_RECV;
        i_rx_byte  = 8'd0;
        i_stall    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = hfbr_pkg::CFG_BLOCK_SIZE;
        i_cfg_data = '0;
        pin_on     = 1'b0;
        pin_res    = '0;
        foreach (blk_mem[i]) blk_mem[i] = 8'd0;
        foreach (blk_len[i]) blk_len[i] = 0;
        wr_slot   = 0;
        rd_slot   = 0;
        fill_cnt  = 0;
        in_block  = 1'b0;
        ovf_flag  = 1'b0;
        cfg_bsize = hfbr_pkg::BLOCK_SIZE_RST;
        cfg_hlen  = hfbr_pkg::HEADER_LEN_RST;
        cfg_hdr   = hfbr_pkg::HEADER_BYTES_RST;
        send_idle_pct  = 22;
        recv_stall_pct = 55;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty ring, unused action, header framing at reset settings
        rows.push_back(row_pin(hfbr_pkg::ACT_READ, 8'h00,
                               8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0));
        rows.push_back(row_pin(hfbr_pkg::ACT_PEEK, 8'h5A,
                               8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0));
        rows.push_back(row_pin(ACT_UNUSED, 8'hFF,
                               8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0));
        rows.push_back(row_pin(hfbr_pkg::ACT_RECV, 8'h00,
                               8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0));
        rows.push_back(row_pin(hfbr_pkg::ACT_RECV, 8'hAA,
                               8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 3'd0, 1'b1));
        rows.push_back(row_pin(hfbr_pkg::ACT_RECV, 8'hAA,
                               8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0));
        // no header: any byte starts a block
        rows.push_back(row_cfg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd2));
        rows.push_back(row_cfg(hfbr_pkg::CFG_HEADER_LEN, 32'd0));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'hFF));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h00));
        rows.push_back(row_item(hfbr_pkg::ACT_PEEK, 8'h00));
        rows.push_back(row_item(hfbr_pkg::ACT_READ, 8'h00));
        // size zero acts as one, header length clamps to four and outruns the block
        rows.push_back(row_cfg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd0));
        rows.push_back(row_cfg(hfbr_pkg::CFG_HEADER_LEN, 32'd7));
        rows.push_back(row_cfg(hfbr_pkg::CFG_HEADER_BYTES, 32'h0403_0201));
        rows.push_back(row_pin(hfbr_pkg::ACT_RECV, 8'h01,
                               8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0));
        rows.push_back(row_pin(hfbr_pkg::ACT_READ, 8'h00,
                               8'h01, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0));
        // oversized block, then size lowered in the middle of it
        rows.push_back(row_cfg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd127));
        rows.push_back(row_cfg(hfbr_pkg::CFG_HEADER_LEN, 32'd4));
        rows.push_back(row_cfg(hfbr_pkg::CFG_HEADER_BYTES, 32'hFEDC_BA98));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h98));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'hBA));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'hDC));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'hFE));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h5A));
        rows.push_back(row_cfg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd2));
        rows.push_back(row_pin(hfbr_pkg::ACT_RECV, 8'hA5,
                               8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0));
        // fill the ring with one-byte blocks until a byte is rejected
        rows.push_back(row_cfg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd1));
        rows.push_back(row_cfg(hfbr_pkg::CFG_HEADER_LEN, 32'd0));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h11));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h22));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h33));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h44));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h55));
        rows.push_back(row_item(hfbr_pkg::ACT_RECV, 8'h66));
        rows.push_back(row_pin(hfbr_pkg::ACT_RECV, 8'h77,
                               8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 3'd7, 1'b0));

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                settle_idle();
                write_reg(rows[r].sel, rows[r].value);
            end else begin
                pin_on  = rows[r].pinned;
                pin_res = rows[r].result;
                send_item(rows[r].sel, rows[r].value[7:0]);
                pin_on  = 1'b0;
            end
        end

        for (p = 0; p < 9; p++) begin
            settle_idle();
            send_idle_pct  = (p < 3) ? 22 : (p < 6) ? 55 : 0;
            recv_stall_pct = (p < 3) ? 55 : (p < 6) ? 22 : 0;
            case (p)
                1: begin
                    write_reg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd0);
                    write_reg(hfbr_pkg::CFG_HEADER_LEN, $urandom_range(0, 2));
                end
                4: begin
                    write_reg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd127);
                    write_reg(hfbr_pkg::CFG_HEADER_LEN, 32'd4);
                end
                7: begin
                    write_reg(hfbr_pkg::CFG_BLOCK_SIZE, 32'd64);
                    write_reg(hfbr_pkg::CFG_HEADER_LEN, $urandom_range(0, 7));
                end
                default: begin
                    write_reg(hfbr_pkg::CFG_BLOCK_SIZE, $urandom_range(1, 8));
                    write_reg(hfbr_pkg::CFG_HEADER_LEN, $urandom_range(0, 7));
                end
            endcase
            write_reg(hfbr_pkg::CFG_HEADER_BYTES, $urandom());
            sent = 0;
            while (sent < 21) begin
                pick = $urandom_range(0, 99);
                hl   = eff_hlen();
                bs   = eff_bsize();
                if (pick < 58) begin
                    // well-formed block: header then random payload
                    for (k = 0; k < bs; k++)
                        send_item(hfbr_pkg::ACT_RECV, (k < hl) ? hdr_byte(k) : 8'($urandom));
                    sent += bs;
                end else if (pick < 68 && hl >= 2) begin
                    // header broken after a correct prefix
                    cut = $urandom_range(1, hl - 1);
                    for (k = 0; k < cut; k++) send_item(hfbr_pkg::ACT_RECV, hdr_byte(k));
                    send_item(hfbr_pkg::ACT_RECV, hdr_byte(cut) ^ 8'($urandom_range(1, 255)));
                    sent += cut + 1;
                end else if (pick < 76) begin
                    send_item(hfbr_pkg::ACT_RECV, 8'($urandom));
                    sent++;
                end else if (pick < 95) begin
                    send_item((pick < 86) ? hfbr_pkg::ACT_READ : hfbr_pkg::ACT_PEEK,
                              8'($urandom));
                    sent++;
                end else begin
                    send_item(ACT_UNUSED, 8'($urandom));
                    sent++;
                end
            end
        end

        settle_idle();
        repeat (70) @(negedge i_clk);
        if (errors == 0) begin
            $display("header_framed_block_receiver_unit: match");
        end else begin
            $display("header_framed_block_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule
